FILE: rtl/core/pwie_pkg.sv
package pwie_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int MIN_FILL  = 14;
  localparam int SLOW_SPAN = 26;
  localparam logic [22:0] RSI_FULL = 23'd6553600;
  localparam logic [22:0] RSI_HALF = 23'd3276800;
  localparam int RSI_PCT = 100;

  // EMA update: e = (2*(p<<16) + (span-1)*e) / (span+1)
  localparam int FAST_MUL   = 11;
  localparam int FAST_DIV   = 13;
  localparam int FAST_RECIP = 5041;   // floor(2^16 / 13)
  localparam int SLOW_MUL   = 25;
  localparam int SLOW_DIV   = 27;
  localparam int SLOW_RECIP = 2427;   // floor(2^16 / 27)
  localparam int EMA_DIGITS = 7;      // 56-bit numerator, one byte a step

  localparam logic [6:0] RSI_QBITS  = 7'd23;
  localparam logic [6:0] MEAN_QBITS = 7'd32;
  localparam logic [6:0] VAR_QBITS  = 7'd63;
  localparam logic [6:0] POS_QBITS  = 7'd16;

  localparam logic [7:0] REG_RSI_PERIOD  = 8'd0;
  localparam logic [7:0] REG_BAND_PERIOD = 8'd1;
  localparam logic [5:0] RSI_PERIOD_RST  = 6'd14;
  localparam logic [6:0] BAND_PERIOD_RST = 7'd20;

  localparam logic [4:0] OP_NONE      = 5'd0;
  localparam logic [4:0] OP_START     = 5'd1;
  localparam logic [4:0] OP_WLD       = 5'd2;
  localparam logic [4:0] OP_EMA       = 5'd3;
  localparam logic [4:0] OP_RSI_FIX   = 5'd4;
  localparam logic [4:0] OP_RSI_GO    = 5'd5;
  localparam logic [4:0] OP_RSI_TAKE  = 5'd6;
  localparam logic [4:0] OP_MEAN_GO   = 5'd7;
  localparam logic [4:0] OP_MEAN_TAKE = 5'd8;
  localparam logic [4:0] OP_VLD       = 5'd9;
  localparam logic [4:0] OP_VMUL      = 5'd10;
  localparam logic [4:0] OP_VACC      = 5'd11;
  localparam logic [4:0] OP_VDIV_GO   = 5'd12;
  localparam logic [4:0] OP_VDIV_TAKE = 5'd13;
  localparam logic [4:0] OP_SQRT      = 5'd14;
  localparam logic [4:0] OP_POS_SET   = 5'd15;
  localparam logic [4:0] OP_POS_GO    = 5'd16;
  localparam logic [4:0] OP_POS_TAKE  = 5'd17;
  localparam logic [4:0] OP_FINISH    = 5'd18;

  typedef struct packed {
    logic [4:0] op;
    logic       rd;
  } cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic walk_first;
    logic walk_last;
    logic ema_last;
    logic rsi_div;
    logic band_ok;
    logic var_last;
    logic div_done;
    logic sqrt_last;
    logic pos_div;
    logic out_free;
  } stat_t;

  // Quotient of a narrow value by a small constant: reciprocal estimate,
  // then one correction step.
  function automatic logic [7:0] const_div(input logic [12:0] t, input logic [4:0] d,
                                           input logic [12:0] m);
    logic [25:0] prod;
    logic [9:0]  q_est;
    logic [12:0] r_est;
    prod  = 26'(t) * 26'(m);
    q_est = prod[25:16];
    r_est = t - 13'(q_est) * 13'(d);
    if (r_est >= 13'(d)) begin
      q_est = q_est + 10'd1;
    end
    return q_est[7:0];
  endfunction

endpackage

FILE: rtl/core/pwie_ram.sv
module pwie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/pwie_div.sv
module pwie_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [38:0] rem_init,
  input  logic [63:0] low_init,
  input  logic [38:0] divisor,
  input  logic [6:0]  nbits,
  output logic [63:0] quot,
  output logic        done
);

  logic [38:0] rem;
  logic [63:0] low;
  logic [38:0] dvs;
  logic [6:0]  cnt;
  logic        busy;
  logic [39:0] trial;
  logic        ge;

  // Restoring division: dividend bits leave the top of low, quotient bits
  // enter at the bottom.
  assign trial = {rem, low[63]};
  assign ge    = trial >= {1'b0, dvs};
  assign quot  = low;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= nbits;
    end else if (busy) begin
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= rem_init;
      low <= low_init;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? 39'(trial - {1'b0, dvs}) : trial[38:0];
      low <= {low[62:0], ge};
    end
  end

endmodule

FILE: rtl/core/pwie_dp.sv
module pwie_dp #(
  parameter int WINDOW_DEPTH = pwie_pkg::DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  pwie_pkg::cmd_t  cmd,
  output pwie_pkg::stat_t st,
  input  logic [31:0]     price,
  input  logic [5:0]      rsi_period,
  input  logic [6:0]      band_period,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [175:0]    m_tdata,
  output logic [1:0]      m_tuser
);
  import pwie_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int FW = $clog2(WINDOW_DEPTH + 1);
  localparam int CW = FW + 8;

  logic [FW-1:0] fill;
  logic [AW-1:0] head;
  logic [AW-1:0] ptr;
  logic [FW-1:0] k;
  logic [31:0]   price_r;
  logic [31:0]   x;

  logic [47:0]   e12, e26;
  logic [55:0]   n12, n26;
  logic [3:0]    r12;
  logic [4:0]    r26;
  logic [2:0]    dcnt;

  logic [31:0]   prev, last;
  logic [37:0]   gsum, lsum;
  logic [38:0]   bsum;
  logic [31:0]   mean;
  logic [31:0]   dabs;
  logic [63:0]   sq;
  logic [70:0]   vsum;
  logic [63:0]   sq_v;
  logic [33:0]   sq_rem;
  logic [31:0]   sigma;
  logic [4:0]    scnt;
  logic [22:0]   rsi;
  logic [17:0]   pos;

  // period values, zero acts as one
  logic [5:0]    pe;
  logic [6:0]    ne;
  logic [CW-1:0] fill_c, k_c, pe_c, ne_c;
  logic          rsi_short, band_ok, in_rsi, in_band, fill_full;

  logic [AW-1:0] ptr_inc;
  logic [AW:0]   tail_sum, bs_sum;
  logic [AW-1:0] wr_addr, band_start;
  logic          ram_we;

  logic [12:0]   t12, t26;
  logic [7:0]    q12, q26;
  logic [55:0]   n12_next, n26_next;

  logic [44:0]   g100;
  logic [31:0]   mag;
  logic          neg;
  logic [33:0]   four_sig;
  logic          sigma_zero, pos_clamp;

  logic [34:0]   rem_t, root_trial;
  logic          root_ge;

  logic          div_start, div_done;
  logic [38:0]   div_rem, div_dvs;
  logic [63:0]   div_low, div_q;
  logic [6:0]    div_nbits;

  logic [48:0]   ema_diff;
  logic [47:0]   ema_mag;
  logic [32:0]   macd_mag, macd;
  logic          bvalid;
  logic [33:0]   lower, upper;

  assign pe = (rsi_period == 6'd0) ? 6'd1 : rsi_period;
  assign ne = (band_period == 7'd0) ? 7'd1 : band_period;
  assign fill_c = CW'(fill);
  assign k_c    = CW'(k);
  assign pe_c   = CW'(pe);
  assign ne_c   = CW'(ne);
  assign rsi_short = fill_c < pe_c + CW'(1);
  assign band_ok   = fill_c >= ne_c;
  assign in_rsi    = (k != '0) && (k_c + pe_c >= fill_c);
  assign in_band   = k_c + ne_c >= fill_c;
  assign fill_full = fill == FW'(WINDOW_DEPTH);

  assign ptr_inc  = (ptr == AW'(WINDOW_DEPTH - 1)) ? '0 : ptr + AW'(1);
  assign tail_sum = (AW+1)'(head) + (AW+1)'(fill);
  assign bs_sum   = (AW+1)'(head) + (AW+1)'(fill - FW'(ne));
  assign wr_addr  = fill_full ? head :
                    (tail_sum >= (AW+1)'(WINDOW_DEPTH)) ?
                    AW'(tail_sum - (AW+1)'(WINDOW_DEPTH)) : tail_sum[AW-1:0];
  assign band_start = (bs_sum >= (AW+1)'(WINDOW_DEPTH)) ?
                      AW'(bs_sum - (AW+1)'(WINDOW_DEPTH)) : bs_sum[AW-1:0];
  assign ram_we = cmd.op == OP_FINISH;

  pwie_ram #(.WIDTH(32), .DEPTH(WINDOW_DEPTH)) u_win (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (price_r),
    .re    (cmd.rd),
    .raddr (ptr),
    .rdata (x)
  );

  // one byte of each EMA division per cycle
  assign t12 = 13'({r12, n12[55:48]});
  assign t26 = {r26, n26[55:48]};
  assign q12 = const_div(t12, 5'(FAST_DIV), 13'(FAST_RECIP));
  assign q26 = const_div(t26, 5'(SLOW_DIV), 13'(SLOW_RECIP));
  assign n12_next = {n12[47:0], q12};
  assign n26_next = {n26[47:0], q26};

  assign g100       = 45'(gsum) * 45'(RSI_PCT);
  assign neg        = last < mean;
  assign mag        = neg ? mean - last : last - mean;
  assign four_sig   = {sigma, 2'b00};
  assign sigma_zero = sigma == '0;
  assign pos_clamp  = 34'(mag) >= four_sig;

  assign rem_t      = {sq_rem[32:0], sq_v[63:62]};
  assign root_trial = {1'b0, sigma, 2'b01};
  assign root_ge    = rem_t >= root_trial;

  always_comb begin
    div_start = 1'b0;
    div_rem   = '0;
    div_low   = '0;
    div_dvs   = 39'd1;
    div_nbits = RSI_QBITS;
    case (cmd.op)
      OP_RSI_GO: begin
        div_start = 1'b1;
        div_rem   = 39'(g100 >> 7);
        div_low   = {g100[6:0], 16'b0, 41'b0};
        div_dvs   = 39'(gsum) + 39'(lsum);
        div_nbits = RSI_QBITS;
      end
      OP_MEAN_GO: begin
        div_start = 1'b1;
        div_rem   = 39'(bsum[38:32]);
        div_low   = {bsum[31:0], 32'b0};
        div_dvs   = 39'(ne);
        div_nbits = MEAN_QBITS;
      end
      OP_VDIV_GO: begin
        div_start = 1'b1;
        div_rem   = 39'(vsum[70:63]);
        div_low   = {vsum[62:0], 1'b0};
        div_dvs   = 39'(ne);
        div_nbits = VAR_QBITS;
      end
      OP_POS_GO: begin
        div_start = 1'b1;
        div_rem   = 39'(mag);
        div_low   = '0;
        div_dvs   = 39'(four_sig);
        div_nbits = POS_QBITS;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  pwie_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem),
    .low_init (div_low),
    .divisor  (div_dvs),
    .nbits    (div_nbits),
    .quot     (div_q),
    .done     (div_done)
  );

  // MACD: magnitude rounded half up, sign kept
  assign ema_diff = {1'b0, e12} - {1'b0, e26};
  assign ema_mag  = ema_diff[48] ? 48'(-ema_diff) : ema_diff[47:0];
  assign macd_mag = 33'((49'(ema_mag) + 49'd32768) >> 16);
  assign macd     = (fill_c < CW'(SLOW_SPAN)) ? '0 :
                    ema_diff[48] ? -macd_mag : macd_mag;
  assign bvalid   = band_ok;
  assign lower    = 34'(mean) - 34'({sigma, 1'b0});
  assign upper    = 34'(mean) + 34'({sigma, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      head     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.op == OP_FINISH) begin
        m_tvalid <= 1'b1;
        if (fill_full) begin
          head <= (head == AW'(WINDOW_DEPTH - 1)) ? '0 : head + AW'(1);
        end else begin
          fill <= fill + FW'(1);
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_START: begin
        price_r <= price;
        k       <= '0;
        ptr     <= head;
        gsum    <= '0;
        lsum    <= '0;
        bsum    <= '0;
        e12     <= '0;
        e26     <= '0;
      end
      OP_WLD: begin
        if (k == '0) begin
          e12 <= 48'(x) << 16;
          e26 <= 48'(x) << 16;
          k   <= k + FW'(1);
          ptr <= ptr_inc;
        end
        n12  <= (56'(x) << 17) + 56'(e12) * 56'(FAST_MUL);
        n26  <= (56'(x) << 17) + 56'(e26) * 56'(SLOW_MUL);
        r12  <= '0;
        r26  <= '0;
        dcnt <= '0;
        if (in_rsi) begin
          if (x > prev) begin
            gsum <= gsum + 38'(x - prev);
          end else begin
            lsum <= lsum + 38'(prev - x);
          end
        end
        if (in_band) begin
          bsum <= bsum + 39'(x);
        end
        prev <= x;
        last <= x;
      end
      OP_EMA: begin
        n12  <= n12_next;
        n26  <= n26_next;
        r12  <= 4'(t12 - 13'(q12) * 13'(FAST_DIV));
        r26  <= 5'(t26 - 13'(q26) * 13'(SLOW_DIV));
        dcnt <= dcnt + 3'd1;
        if (dcnt == 3'(EMA_DIGITS - 1)) begin
          e12 <= n12_next[47:0];
          e26 <= n26_next[47:0];
          k   <= k + FW'(1);
          ptr <= ptr_inc;
        end
      end
      OP_RSI_FIX: begin
        rsi <= rsi_short ? RSI_HALF : RSI_FULL;
      end
      OP_RSI_TAKE: begin
        rsi <= div_q[22:0];
      end
      OP_MEAN_TAKE: begin
        mean <= div_q[31:0];
        ptr  <= band_start;
        k    <= '0;
        vsum <= '0;
      end
      OP_VLD: begin
        dabs <= (x >= mean) ? x - mean : mean - x;
      end
      OP_VMUL: begin
        sq <= 64'(dabs) * 64'(dabs);
      end
      OP_VACC: begin
        vsum <= vsum + 71'(sq);
        k    <= k + FW'(1);
        ptr  <= ptr_inc;
      end
      OP_VDIV_TAKE: begin
        sq_v   <= {1'b0, div_q[62:0]};
        sq_rem <= '0;
        sigma  <= '0;
        scnt   <= '0;
      end
      OP_SQRT: begin
        sq_v   <= {sq_v[61:0], 2'b00};
        scnt   <= scnt + 5'd1;
        if (root_ge) begin
          sq_rem <= 34'(rem_t - root_trial);
          sigma  <= {sigma[30:0], 1'b1};
        end else begin
          sq_rem <= rem_t[33:0];
          sigma  <= {sigma[30:0], 1'b0};
        end
      end
      OP_POS_SET: begin
        if (sigma_zero) begin
          pos <= '0;
        end else begin
          pos <= neg ? -18'sd65536 : 18'sd65536;
        end
      end
      OP_POS_TAKE: begin
        pos <= neg ? -18'(div_q[15:0]) : 18'(div_q[15:0]);
      end
      OP_FINISH: begin
        m_tdata <= {2'b00,
                    bvalid ? pos : 18'd0,
                    bvalid ? upper : 34'd0,
                    bvalid ? mean : 32'd0,
                    bvalid ? lower : 34'd0,
                    macd,
                    rsi};
        m_tuser <= {bvalid, fill_c >= CW'(MIN_FILL)};
      end
      default: begin
        prev <= prev;
      end
    endcase
  end

  always_comb begin
    st.fill_zero  = fill == '0;
    st.walk_first = k == '0;
    st.walk_last  = k_c + CW'(1) == fill_c;
    st.ema_last   = dcnt == 3'(EMA_DIGITS - 1);
    st.rsi_div    = !rsi_short && (lsum != '0);
    st.band_ok    = band_ok;
    st.var_last   = k_c + CW'(1) == ne_c;
    st.div_done   = div_done;
    st.sqrt_last  = scnt == 5'd31;
    st.pos_div    = !sigma_zero && !pos_clamp;
    st.out_free   = !m_tvalid || m_tready;
  end

endmodule

FILE: rtl/core/pwie_ctrl.sv
module pwie_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  pwie_pkg::stat_t st,
  output pwie_pkg::cmd_t  cmd
);
  import pwie_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_WRD   = 5'd1;
  localparam logic [4:0] S_WLD   = 5'd2;
  localparam logic [4:0] S_WEMA  = 5'd3;
  localparam logic [4:0] S_RSI   = 5'd4;
  localparam logic [4:0] S_RSIW  = 5'd5;
  localparam logic [4:0] S_MEAN  = 5'd6;
  localparam logic [4:0] S_MEANW = 5'd7;
  localparam logic [4:0] S_VRD   = 5'd8;
  localparam logic [4:0] S_VLD   = 5'd9;
  localparam logic [4:0] S_VMUL  = 5'd10;
  localparam logic [4:0] S_VACC  = 5'd11;
  localparam logic [4:0] S_VDIV  = 5'd12;
  localparam logic [4:0] S_VDIVW = 5'd13;
  localparam logic [4:0] S_SQRT  = 5'd14;
  localparam logic [4:0] S_POS   = 5'd15;
  localparam logic [4:0] S_POSW  = 5'd16;
  localparam logic [4:0] S_OUT   = 5'd17;

  logic [4:0] state, state_next;

  assign s_tready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.rd     = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = OP_START;
          state_next = st.fill_zero ? S_RSI : S_WRD;
        end
      end
      S_WRD: begin
        cmd.rd     = 1'b1;
        state_next = S_WLD;
      end
      S_WLD: begin
        cmd.op = OP_WLD;
        if (st.walk_first) begin
          state_next = st.walk_last ? S_RSI : S_WRD;
        end else begin
          state_next = S_WEMA;
        end
      end
      S_WEMA: begin
        cmd.op = OP_EMA;
        if (st.ema_last) begin
          state_next = st.walk_last ? S_RSI : S_WRD;
        end
      end
      S_RSI: begin
        if (st.rsi_div) begin
          cmd.op     = OP_RSI_GO;
          state_next = S_RSIW;
        end else begin
          cmd.op     = OP_RSI_FIX;
          state_next = S_MEAN;
        end
      end
      S_RSIW: begin
        if (st.div_done) begin
          cmd.op     = OP_RSI_TAKE;
          state_next = S_MEAN;
        end
      end
      S_MEAN: begin
        if (st.band_ok) begin
          cmd.op     = OP_MEAN_GO;
          state_next = S_MEANW;
        end else begin
          state_next = S_OUT;
        end
      end
      S_MEANW: begin
        if (st.div_done) begin
          cmd.op     = OP_MEAN_TAKE;
          state_next = S_VRD;
        end
      end
      S_VRD: begin
        cmd.rd     = 1'b1;
        state_next = S_VLD;
      end
      S_VLD: begin
        cmd.op     = OP_VLD;
        state_next = S_VMUL;
      end
      S_VMUL: begin
        cmd.op     = OP_VMUL;
        state_next = S_VACC;
      end
      S_VACC: begin
        cmd.op     = OP_VACC;
        state_next = st.var_last ? S_VDIV : S_VRD;
      end
      S_VDIV: begin
        cmd.op     = OP_VDIV_GO;
        state_next = S_VDIVW;
      end
      S_VDIVW: begin
        if (st.div_done) begin
          cmd.op     = OP_VDIV_TAKE;
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (st.sqrt_last) begin
          state_next = S_POS;
        end
      end
      S_POS: begin
        if (st.pos_div) begin
          cmd.op     = OP_POS_GO;
          state_next = S_POSW;
        end else begin
          cmd.op     = OP_POS_SET;
          state_next = S_OUT;
        end
      end
      S_POSW: begin
        if (st.div_done) begin
          cmd.op     = OP_POS_TAKE;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.op     = OP_FINISH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/price_window_indicator_engine.sv
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  s_tdata: price (Q16.16)
// m_*       out        m_tvalid / m_tready  m_tdata: indicators, m_tuser: valid flags
// cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data (register write)
//
// One price at a time. The walk over the window is set by the EMA division,
// one byte per cycle; the tail is set by the shared bit-serial divider
// (23, 32, 63 and 16 steps) and a 32-step root.
// Reset empties the window (fill 0) and loads default periods; window memory
// contents stay undefined and need no clearing pass.
// A stalled result sits in the output register; the next price is taken
// meanwhile, and the block holds before loading a new result until the old
// one is gone.
module price_window_indicator_engine #(
  parameter int WINDOW_DEPTH = pwie_pkg::DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // [31:0] price
  output logic         m_tvalid,
  input  logic         m_tready,
  // [22:0] rsi_value, [55:23] macd_value, [89:56] band_lower,
  // [121:90] band_middle, [155:122] band_upper, [173:156] band_position
  output logic [175:0] m_tdata,
  output logic [1:0]   m_tuser,   // [0] indicators_valid, [1] band_valid
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [6:0]   cfg_data
);
  import pwie_pkg::*;

  logic [5:0] rsi_period;
  logic [6:0] band_period;
  cmd_t       cmd;
  stat_t      st;

  // Configuration words land at any time; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsi_period  <= RSI_PERIOD_RST;
      band_period <= BAND_PERIOD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RSI_PERIOD:  rsi_period  <= cfg_data[5:0];
        REG_BAND_PERIOD: band_period <= cfg_data;
        default: begin
          band_period <= band_period;
        end
      endcase
    end
  end

  // Sequencer: walks the window, then runs the divider and root steps.
  pwie_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // Window memory, accumulators, EMA, divider, root and output register.
  pwie_dp #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .price       (s_tdata),
    .rsi_period  (rsi_period),
    .band_period (band_period),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  // only one price in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second price accepted while busy");

  a_rsi_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[22:0] <= RSI_FULL))
    else $error("rsi above 100");

  a_band_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[1]) |-> (m_tdata[173:56] == '0))
    else $error("band fields set without band valid");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[173:156]) >= -18'sd65536 &&
                  $signed(m_tdata[173:156]) <= 18'sd65536))
    else $error("band position out of range");

endmodule
